[rtl/mutf8_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutf8_pkg
// Shared types and constants for the modified-UTF-8 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package mutf8_pkg;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TWO   = 2'd1;
    localparam logic [1:0] ERR_THREE = 2'd2;
    localparam logic [1:0] ERR_LEAD  = 2'd3;

    localparam logic [7:0] QMARK = 8'h3F;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // one decoded word group: up to four results of one input word
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            present;
        logic            str_end;
        logic [1:0]      err;
    } op_t;

endpackage

[rtl/mutf8_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutf8_in_if
// Input channel: one modified-UTF-8 payload word per handshake.
// ----------------------------------------------------------------------------
interface mutf8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       has_byte;
    logic       string_last;

    modport source (output valid, output in_byte, output has_byte, output string_last,
                    input ready);
    modport sink   (input valid, input in_byte, input has_byte, input string_last,
                    output ready);
endinterface

[rtl/mutf8_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutf8_out_if
// Output channel: one UTF-8 byte, end marker or error marker per handshake.
// ----------------------------------------------------------------------------
interface mutf8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_last;
    logic       string_end;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output byte_present, output run_last,
                    output string_end, output error_code, input ready);
    modport sink   (input valid, input out_byte, input byte_present, input run_last,
                    input string_end, input error_code, output ready);
endinterface

[rtl/mutf8_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutf8_front
// Accepts input words, decodes modified UTF-8, pairs surrogates and pushes
// at most one result group per word into the queue.
// ----------------------------------------------------------------------------
module mutf8_front
(
    input  logic            clk,
    input  logic            rst_n,
    mutf8_in_if.sink        items,
    input  logic            q_space,
    output logic            push,
    output mutf8_pkg::op_t  push_op
);

    logic [1:0]  need_reg, need_next;
    logic [1:0]  len_reg, len_next;
    logic [15:0] pu_reg, pu_next;
    logic        hp_reg, hp_next;
    logic [9:0]  hh_reg, hh_next;
    logic        drop_reg, drop_next;

    logic        acc;
    logic [7:0]  b;
    logic        last;

    assign items.ready = q_space;
    assign acc  = items.valid && items.ready;
    assign b    = items.in_byte;
    assign last = items.string_last;

    always_comb
    begin
        logic            unit_v;
        logic [15:0]     unit;
        logic [15:0]     cat;
        logic            err_v;
        logic [1:0]      err;
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
        logic            is_high;
        logic            is_low;
        logic [20:0]     cp;

        need_next = need_reg;
        len_next  = len_reg;
        pu_next   = pu_reg;
        hp_next   = hp_reg;
        hh_next   = hh_reg;
        drop_next = drop_reg;
        unit_v    = 1'b0;
        unit      = '0;
        cat       = {pu_reg[9:0], b[5:0]};
        err_v     = 1'b0;
        err       = mutf8_pkg::ERR_NONE;
        bytes     = '0;
        n         = 3'd0;
        is_high   = 1'b0;
        is_low    = 1'b0;
        cp        = '0;
        push      = 1'b0;
        push_op   = '0;

        if (acc)
        begin
            if (drop_reg)
            begin
                if (last)
                begin
                    drop_next = 1'b0;
                end
            end
            else
            begin
                if (items.has_byte)
                begin
                    if (need_reg == 2'd0)
                    begin
                        priority if (!b[7])
                        begin
                            unit_v = 1'b1;
                            unit   = {8'h00, b};
                        end
                        else if (b[7:5] == 3'b110)
                        begin
                            pu_next   = {11'h000, b[4:0]};
                            need_next = 2'd1;
                            len_next  = 2'd2;
                        end
                        else if (b[7:4] == 4'b1110)
                        begin
                            pu_next   = {12'h000, b[3:0]};
                            need_next = 2'd2;
                            len_next  = 2'd3;
                        end
                        else
                        begin
                            err_v = 1'b1;
                            err   = mutf8_pkg::ERR_LEAD;
                        end
                    end
                    else if (b[7:6] != 2'b10)
                    begin
                        err_v = 1'b1;
                        err   = (len_reg == 2'd2) ? mutf8_pkg::ERR_TWO : mutf8_pkg::ERR_THREE;
                    end
                    else
                    begin
                        need_next = need_reg - 2'd1;
                        if (need_reg == 2'd1)
                        begin
                            unit_v   = 1'b1;
                            unit     = cat;
                            pu_next  = '0;
                            len_next = 2'd0;
                        end
                        else
                        begin
                            pu_next = cat;
                        end
                    end
                end

                is_high = (unit[15:10] == 6'b110110);
                is_low  = (unit[15:10] == 6'b110111);
                cp      = 21'h10000 + {1'b0, hh_reg, 10'h000} + {11'h000, unit[9:0]};

                if (!err_v && unit_v)
                begin
                    if (hp_reg && is_low)
                    begin
                        bytes[0] = {5'b11110, cp[20:18]};
                        bytes[1] = {2'b10, cp[17:12]};
                        bytes[2] = {2'b10, cp[11:6]};
                        bytes[3] = {2'b10, cp[5:0]};
                        n        = 3'd4;
                        hp_next  = 1'b0;
                        hh_next  = '0;
                    end
                    else
                    begin
                        if (hp_reg)
                        begin
                            bytes[n[1:0]] = mutf8_pkg::QMARK;
                            n             = n + 3'd1;
                        end
                        hp_next = 1'b0;
                        hh_next = '0;
                        priority if (is_high)
                        begin
                            hp_next = 1'b1;
                            hh_next = unit[9:0];
                        end
                        else if (is_low)
                        begin
                            bytes[n[1:0]] = mutf8_pkg::QMARK;
                            n             = n + 3'd1;
                        end
                        else if (unit[15:7] == 9'h000)
                        begin
                            bytes[n[1:0]] = unit[7:0];
                            n             = n + 3'd1;
                        end
                        else if (unit[15:11] == 5'h00)
                        begin
                            bytes[n[1:0]] = {3'b110, unit[10:6]};
                            n             = n + 3'd1;
                            bytes[n[1:0]] = {2'b10, unit[5:0]};
                            n             = n + 3'd1;
                        end
                        else
                        begin
                            bytes[n[1:0]] = {4'b1110, unit[15:12]};
                            n             = n + 3'd1;
                            bytes[n[1:0]] = {2'b10, unit[11:6]};
                            n             = n + 3'd1;
                            bytes[n[1:0]] = {2'b10, unit[5:0]};
                            n             = n + 3'd1;
                        end
                    end
                end

                if (!err_v && last && need_next != 2'd0)
                begin
                    err_v = 1'b1;
                    err   = (len_next == 2'd2) ? mutf8_pkg::ERR_TWO : mutf8_pkg::ERR_THREE;
                end

                if (err_v)
                begin
                    need_next        = '0;
                    len_next         = '0;
                    pu_next          = '0;
                    hp_next          = 1'b0;
                    hh_next          = '0;
                    drop_next        = !last;
                    push             = 1'b1;
                    push_op.bytes    = '0;
                    push_op.last_idx = 2'd0;
                    push_op.present  = 1'b0;
                    push_op.str_end  = 1'b1;
                    push_op.err      = err;
                end
                else
                begin
                    push_op.present = 1'b1;
                    if (last)
                    begin
                        if (hp_next)
                        begin
                            bytes[n[1:0]] = mutf8_pkg::QMARK;
                            n             = n + 3'd1;
                        end
                        if (n == 3'd0)
                        begin
                            push_op.present = 1'b0;
                            n               = 3'd1;
                        end
                        push_op.str_end = 1'b1;
                        need_next       = '0;
                        len_next        = '0;
                        pu_next         = '0;
                        hp_next         = 1'b0;
                        hh_next         = '0;
                    end
                    push             = (n != 3'd0);
                    push_op.bytes    = bytes;
                    push_op.last_idx = 2'(n - 3'd1);
                    push_op.err      = mutf8_pkg::ERR_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= '0;
            len_reg  <= '0;
            pu_reg   <= '0;
            hp_reg   <= 1'b0;
            hh_reg   <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            need_reg <= need_next;
            len_reg  <= len_next;
            pu_reg   <= pu_next;
            hp_reg   <= hp_next;
            hh_reg   <= hh_next;
            drop_reg <= drop_next;
        end
    end

endmodule

[rtl/mutf8_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutf8_queue
// Small FIFO of result groups between the decoder and the byte emitter.
// ----------------------------------------------------------------------------
module mutf8_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mutf8_pkg::op_t  push_op,
    output logic            space,
    input  logic            pop,
    output logic            head_valid,
    output mutf8_pkg::op_t  head
);

    mutf8_pkg::op_t mem [mutf8_pkg::QDEPTH];

    logic [mutf8_pkg::QPTR_W-1:0] wr_reg;
    logic [mutf8_pkg::QPTR_W-1:0] rd_reg;
    logic [mutf8_pkg::QPTR_W:0]   cnt_reg;

    assign space      = (cnt_reg != (mutf8_pkg::QPTR_W+1)'(mutf8_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

[rtl/mutf8_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutf8_back
// Moves head group bytes to the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module mutf8_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  mutf8_pkg::op_t  head,
    output logic            pop,
    mutf8_out_if.source     results
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       present_reg;
    logic       run_last_reg;
    logic       str_end_reg;
    logic [1:0] err_reg;
    logic       load;
    logic       at_last;

    assign load    = head_valid && (!valid_reg || results.ready);
    assign at_last = (idx_reg == head.last_idx);
    assign pop     = load && at_last;

    assign results.valid        = valid_reg;
    assign results.out_byte     = byte_reg;
    assign results.byte_present = present_reg;
    assign results.run_last     = run_last_reg;
    assign results.string_end   = str_end_reg;
    assign results.error_code   = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (results.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= head.bytes[idx_reg];
            present_reg  <= head.present;
            run_last_reg <= at_last;
            str_end_reg  <= head.str_end && at_last;
            err_reg      <= at_last ? head.err : mutf8_pkg::ERR_NONE;
        end
    end

endmodule

[rtl/mutf8_to_utf8_transcoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutf8_to_utf8_transcoder_top
// Modified-UTF-8 to UTF-8 transcoder: decoder front, 4-deep group queue,
// byte emitter back.
// ----------------------------------------------------------------------------
// Path: group written to the queue, then first result to the output register.
// Throughput: one input word per cycle while the queue has space; the back end
//   sends one result per cycle unless results.ready stalls, so a multi-result
//   word holds the emitter, and the 4-entry queue takes up that burst.
// Reset: rst_n asynchronous, clears decode state, queue pointers, output valid.
// ----------------------------------------------------------------------------
module mutf8_to_utf8_transcoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    mutf8_in_if.sink    items,
    mutf8_out_if.source results
);

    logic           q_space;
    logic           push;
    mutf8_pkg::op_t push_op;
    logic           pop;
    logic           head_valid;
    mutf8_pkg::op_t head;

    mutf8_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .q_space (q_space),
        .push    (push),
        .push_op (push_op)
    );

    mutf8_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .space      (q_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mutf8_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .results    (results)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !q_space))
        else $error("group pushed into full queue");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.byte_present) |-> (results.run_last && results.string_end))
        else $error("marker word does not close the string");

    a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.error_code != mutf8_pkg::ERR_NONE)
            |-> (!results.byte_present && results.out_byte == 8'h00))
        else $error("error word carries a byte");

endmodule
